@@ design/llqd_pkg.sv @@
// Package for the least-loaded queue dispatcher: sizes, field types,
// result status codes and the slot/count pair handed out by the argmin.
// No dependencies.
package llqd_pkg;

  localparam int WORKERS   = 16;
  localparam int DEPTH     = 64;
  localparam int SLOT_W    = $clog2(WORKERS);
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CFG_W     = 5;
  localparam int CONN_W    = 16;
  localparam int POLL_W    = 10;
  localparam int ENTRY_W   = CONN_W + POLL_W;
  localparam int ADDR_W    = SLOT_W + PTR_W;
  localparam int STORE_N   = WORKERS * DEPTH;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Item kind codes
  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Winner of the least-loaded search
  typedef struct packed {
    slot_t slot;
    cnt_t  cnt;
  } pick_t;

endpackage

@@ design/llqd_argmin.sv @@
// Least-loaded slot search: a binary compare tree over the queue counts.
// Depends on llqd_pkg; slots at or above the clamped worker count never win.
module llqd_argmin (
  input  llqd_pkg::cnt_t  counts [llqd_pkg::WORKERS],
  input  llqd_pkg::cfg_t  active_workers,
  output llqd_pkg::pick_t pick
);

  localparam int LEVELS = $clog2(llqd_pkg::WORKERS);
  localparam int LEAVES = 1 << LEVELS;

  llqd_pkg::cfg_t  n_use;
  llqd_pkg::pick_t lvl [LEVELS+1][LEAVES];
  logic            lvl_ok [LEVELS+1][LEAVES];

  // Clamp the worker count to 1..WORKERS
  always_comb begin
    if (active_workers == '0) begin
      n_use = llqd_pkg::CFG_W'(1);
    end else if (active_workers > llqd_pkg::CFG_W'(llqd_pkg::WORKERS)) begin
      n_use = llqd_pkg::CFG_W'(llqd_pkg::WORKERS);
    end else begin
      n_use = active_workers;
    end
  end

  // Reduce pairwise; a tie keeps the left (lower) slot
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        lvl[l][i]    = '0;
        lvl_ok[l][i] = 1'b0;
      end
    end
    for (int i = 0; i < LEAVES; i++) begin
      if (i < llqd_pkg::WORKERS) begin
        lvl[0][i].slot = llqd_pkg::SLOT_W'(i);
        lvl[0][i].cnt  = counts[i];
        lvl_ok[0][i]   = (i < int'(n_use));
      end
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        if (lvl_ok[l][2*i] &&
            (!lvl_ok[l][2*i+1] || lvl[l][2*i].cnt <= lvl[l][2*i+1].cnt)) begin
          lvl[l+1][i] = lvl[l][2*i];
        end else begin
          lvl[l+1][i] = lvl[l][2*i+1];
        end
        lvl_ok[l+1][i] = lvl_ok[l][2*i] || lvl_ok[l][2*i+1];
      end
    end
    pick = lvl[LEVELS][0];
  end

endmodule

@@ design/least_loaded_queue_dispatcher.sv @@
// Least-loaded queue dispatcher: per-worker task FIFOs in one shared store.
// Depends on llqd_pkg and llqd_argmin.
// A submit or an empty pop shows its result from S_EXEC; any other pop goes on to
// S_READ to wait for the registered store read. Throughput: one item at a time;
// busy drops as the result shows.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset (rst, synchronous): all queues empty, pointers zero, 16 active workers;
// the task store is not cleared and needs no clearing pass.
module least_loaded_queue_dispatcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [15:0] conn_id,
  input  logic [9:0]  poll_id,
  input  logic [3:0]  worker_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [15:0] task_conn,
  output logic [9:0]  task_poll
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t                 state;
  llqd_pkg::cfg_t         active_workers;
  llqd_pkg::ptr_t         head [llqd_pkg::WORKERS];
  llqd_pkg::ptr_t         tail [llqd_pkg::WORKERS];
  llqd_pkg::cnt_t         count [llqd_pkg::WORKERS];
  llqd_pkg::entry_t       store [llqd_pkg::STORE_N];
  llqd_pkg::entry_t       rd_data;

  logic                   item_kind;
  logic [15:0]            item_conn;
  logic [9:0]             item_poll;
  llqd_pkg::slot_t        item_widx;

  llqd_pkg::pick_t        pick;
  logic                   full;
  logic                   pop_empty;
  logic                   mem_we;
  logic [llqd_pkg::ADDR_W-1:0] mem_addr;

  function automatic llqd_pkg::ptr_t wrap_next(llqd_pkg::ptr_t p);
    if (p == llqd_pkg::PTR_W'(llqd_pkg::DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  llqd_argmin u_argmin (
    .counts         (count),
    .active_workers (active_workers),
    .pick           (pick)
  );

  assign busy      = (state != S_IDLE);
  assign full      = (pick.cnt >= llqd_pkg::CNT_W'(llqd_pkg::DEPTH));
  assign pop_empty = (count[item_widx] == '0);
  assign mem_we    = (state == S_EXEC) && (item_kind == llqd_pkg::KIND_SUBMIT) && !full;

  // Select the store address: tail of the chosen slot or head of the popped one
  always_comb begin
    if (item_kind == llqd_pkg::KIND_SUBMIT) begin
      mem_addr = {pick.slot, tail[pick.slot]};
    end else begin
      mem_addr = {item_widx, head[item_widx]};
    end
  end

  // Task store: one write or read port, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= {item_poll, item_conn};
    end
    rd_data <= store[mem_addr];
  end

  // Sequence one item and keep the queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      active_workers <= llqd_pkg::CFG_W'(llqd_pkg::WORKERS);
      for (int i = 0; i < llqd_pkg::WORKERS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        active_workers <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_kind <= kind;
            item_conn <= conn_id;
            item_poll <= poll_id;
            item_widx <= worker_index;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          task_conn <= '0;
          task_poll <= '0;
          if (item_kind == llqd_pkg::KIND_SUBMIT) begin
            slot <= pick.slot;
            done <= 1'b1;
            if (full) begin
              status <= llqd_pkg::ST_DROPPED;
            end else begin
              status           <= llqd_pkg::ST_QUEUED;
              tail[pick.slot]  <= wrap_next(tail[pick.slot]);
              count[pick.slot] <= pick.cnt + 1'b1;
            end
            state <= S_IDLE;
          end else if (pop_empty) begin
            status <= llqd_pkg::ST_EMPTY;
            slot   <= item_widx;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            head[item_widx]  <= wrap_next(head[item_widx]);
            count[item_widx] <= count[item_widx] - 1'b1;
            state            <= S_READ;
          end
        end
        S_READ: begin
          status    <= llqd_pkg::ST_POPPED;
          slot      <= item_widx;
          task_conn <= rd_data[llqd_pkg::CONN_W-1:0];
          task_poll <= rd_data[llqd_pkg::ENTRY_W-1:llqd_pkg::CONN_W];
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Check result timing and count bounds
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while an item is still at work");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    pick.cnt <= llqd_pkg::CNT_W'(llqd_pkg::DEPTH))
    else $error("queue count above queue depth");

endmodule

@@ tb/dispatch_checker.sv @@
// Scoreboard for the least-loaded queue dispatcher: keeps a shadow of the
// per-worker task FIFOs, predicts one outcome per accepted item and compares
// it with each done strobe. Depends on llqd_pkg.
module dispatch_checker
  import llqd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        start,
  input  logic        busy,
  input  logic        kind,
  input  logic [15:0] conn_id,
  input  logic [9:0]  poll_id,
  input  logic [3:0]  worker_index,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [3:0]  slot,
  input  logic [15:0] task_conn,
  input  logic [9:0]  task_poll,
  output int          outstanding,
  output int          mismatches
);

  typedef struct {
    status_t             status;
    slot_t               slot;
    logic [CONN_W-1:0]   conn;
    logic [POLL_W-1:0]   poll;
  } outcome_t;

  entry_t   shadow_store [STORE_N];
  ptr_t     shadow_head  [WORKERS];
  ptr_t     shadow_tail  [WORKERS];
  cnt_t     shadow_count [WORKERS];
  cfg_t     shadow_workers;
  outcome_t awaited_outcomes [$];
  int       fail_tally = 0;

  assign mismatches = fail_tally;

  // Clamp the register to the range of queues that dispatch can scan
  function automatic int queues_in_use(cfg_t w);
    if (w == 0) return 1;
    if (int'(w) > WORKERS) return WORKERS;
    return int'(w);
  endfunction

  function automatic ptr_t ptr_advance(ptr_t p);
    return (int'(p) == DEPTH - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  // Apply one item to the shadow queues and work out its outcome
  task automatic dispatch_item(input logic k, input logic [CONN_W-1:0] c,
                               input logic [POLL_W-1:0] p, input slot_t w,
                               output outcome_t o);
    int    n;
    slot_t best;
    cnt_t  best_cnt;
    o.conn = '0;
    o.poll = '0;
    if (k == KIND_SUBMIT) begin
      n = queues_in_use(shadow_workers);
      best = '0;
      best_cnt = shadow_count[0];
      for (int i = 1; i < n; i++) begin
        if (shadow_count[i] < best_cnt) begin
          best_cnt = shadow_count[i];
          best = slot_t'(i);
        end
      end
      o.slot = best;
      if (int'(best_cnt) >= DEPTH) begin
        // every queue in use is full: drop, leave state alone
        o.status = ST_DROPPED;
      end else begin
        o.status = ST_QUEUED;
        shadow_store[int'(best) * DEPTH + int'(shadow_tail[best])] = {p, c};
        shadow_tail[best] = ptr_advance(shadow_tail[best]);
        shadow_count[best] = best_cnt + 1'b1;
      end
    end else begin
      o.slot = w;
      if (int'(w) >= WORKERS || shadow_count[w] == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.status = ST_POPPED;
        {o.poll, o.conn} = shadow_store[int'(w) * DEPTH + int'(shadow_head[w])];
        shadow_head[w] = ptr_advance(shadow_head[w]);
        shadow_count[w] = shadow_count[w] - 1'b1;
      end
    end
  endtask

  // Count a failure; report only the first few
  task automatic flag_failure(input string what);
    fail_tally++;
    if (fail_tally <= 10) $display("%0t: %s", $time, what);
  endtask

  // Retire results first, then take in config writes and new items
  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    if (rst) begin
      for (int i = 0; i < WORKERS; i++) begin
        shadow_head[i] = '0;
        shadow_tail[i] = '0;
        shadow_count[i] = '0;
      end
      shadow_workers = cfg_t'(WORKERS);
      awaited_outcomes.delete();
    end else begin
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          flag_failure($sformatf("result with no item waiting: status %0d slot %0d",
                                 status, slot));
        end else begin
          want = awaited_outcomes.pop_front();
          if (want.status != status || want.slot != slot ||
              want.conn != task_conn || want.poll != task_poll) begin
            flag_failure($sformatf({"mismatch: expected status %0d slot %0d conn %h ",
                                    "poll %h, got status %0d slot %0d conn %h poll %h"},
                                   want.status, want.slot, want.conn, want.poll,
                                   status, slot, task_conn, task_poll));
          end
        end
      end
      if (cfg_we) shadow_workers = cfg_wdata;
      if (start && !busy) begin
        dispatch_item(kind, conn_id, poll_id, worker_index, fresh);
        awaited_outcomes.push_back(fresh);
      end
    end
    outstanding <= awaited_outcomes.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the dispatcher testbench: clock, reset, directed and random items,
// worker-count changes between phases, and the verdict.
// Depends on llqd_pkg, least_loaded_queue_dispatcher and dispatch_checker.
module testbench;
  import llqd_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        start;
  logic        busy;
  logic        kind;
  logic [15:0] conn_id;
  logic [9:0]  poll_id;
  logic [3:0]  worker_index;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [15:0] task_conn;
  logic [9:0]  task_poll;
  int          outstanding;
  int          mismatches;

  bit          steady;

  least_loaded_queue_dispatcher i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .conn_id      (conn_id),
    .poll_id      (poll_id),
    .worker_index (worker_index),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .task_conn    (task_conn),
    .task_poll    (task_poll)
  );

  dispatch_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .conn_id      (conn_id),
    .poll_id      (poll_id),
    .worker_index (worker_index),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .task_conn    (task_conn),
    .task_poll    (task_poll),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hand one item over, after a random gap unless in a no-idle stretch
  task automatic send_item(input logic k, input logic [15:0] c, input logic [9:0] p,
                           input logic [3:0] w);
    int gap;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    conn_id      <= c;
    poll_id      <= p;
    worker_index <= w;
    do @(posedge clk); while (busy);
  endtask

  // Drain every outstanding result, then write the worker count
  task automatic set_workers(input cfg_t v);
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   pct;
    int   n;
    cfg_t v;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    start        <= 1'b0;
    kind         <= KIND_SUBMIT;
    conn_id      <= '0;
    poll_id      <= '0;
    worker_index <= '0;
    steady       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops of empty queues at both ends
    send_item(KIND_POP, 16'hFFFF, 10'h3FF, 4'd0);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd15);
    // Field extremes and alternating bits spread over slots 0..3
    send_item(KIND_SUBMIT, 16'hFFFF, 10'h3FF, 4'd0);
    send_item(KIND_SUBMIT, 16'h0000, 10'h000, 4'd15);
    send_item(KIND_SUBMIT, 16'hAAAA, 10'h155, 4'd5);
    send_item(KIND_SUBMIT, 16'h5555, 10'h2AA, 4'd10);
    send_item(KIND_POP, 16'h1234, 10'h0F0, 4'd0);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd1);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd4);
    // Zero workers acts as one: submits pile on slot 0, higher slots still drain
    set_workers(5'd0);
    send_item(KIND_SUBMIT, 16'h8001, 10'h201, 4'd7);
    send_item(KIND_SUBMIT, 16'h7FFE, 10'h1FE, 4'd7);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd2);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd3);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd3);
    // Oversized setting saturates to all queues
    set_workers(5'd31);
    send_item(KIND_SUBMIT, 16'h0F0F, 10'h0CC, 4'd0);
    send_item(KIND_SUBMIT, 16'hF0F0, 10'h333, 4'd0);
    send_item(KIND_SUBMIT, 16'h00FF, 10'h3C3, 4'd0);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd0);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd0);
    send_item(KIND_POP, 16'h0000, 10'h000, 4'd1);

    // Random phases: each picks a worker count and a submit/pop mix
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin v = 5'd1;  pct = 90; end
        1: begin v = 5'd0;  pct = 25; end
        2: begin v = 5'd2;  pct = 85; end
        3: begin v = 5'd31; pct = 50; end
        4: begin v = 5'd5;  pct = 70; end
        5: begin v = 5'd16; pct = 60; end
        6: begin v = 5'd17; pct = 40; end
        7: begin v = 5'd1;  pct = 95; end
        8: begin v = 5'd3;  pct = 20; end
        default: begin
          v = cfg_t'($urandom_range(0, 31));
          pct = $urandom_range(20, 80);
        end
      endcase
      set_workers(v);
      n = (v == 0) ? 1 : ((int'(v) > WORKERS) ? WORKERS : int'(v));
      for (int j = 0; j < 200; j++) begin
        // mostly pop queues in use, sometimes any queue to drain leftovers
        send_item(($urandom_range(0, 99) < pct) ? KIND_SUBMIT : KIND_POP,
                  16'($urandom), 10'($urandom),
                  ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, n - 1))
                                              : 4'($urandom_range(0, 15)));
      end
    end

    // Drain and settle, then give the verdict
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule
